@@ hw/rtl/smre_pkg.sv @@
// Shared types and constants for the sorted multiset rank engine.
package smre_pkg;

	localparam int CAPACITY    = 256;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = CAPACITY / GROUP_SIZE;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int GPC_W       = $clog2(GROUP_SIZE + 1);
	localparam int NGC_W       = $clog2(NUM_GROUPS + 1);
	localparam int GRP_SH      = $clog2(GROUP_SIZE);
	localparam int VAL_W       = 32;

	localparam logic signed [VAL_W-1:0] PRED_NONE = -32'sd1000000000;
	localparam logic signed [VAL_W-1:0] SUCC_NONE = 32'sd1000000000;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_RANK   = 3'd2,
		OP_KTH    = 3'd3,
		OP_PRED   = 3'd4,
		OP_SUCC   = 3'd5
	} op_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_RED,
		S_FIN
	} state_e;

	typedef struct packed {
		logic [2:0]              operation;
		logic signed [VAL_W-1:0] value;
		logic [8:0]              rank_index;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] answer;
		logic [1:0]              status;
		logic [8:0]              element_total;
	} result_t;

	typedef struct packed {
		logic                    cmp_en;
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic                    lt_full;
		logic [GPC_W-1:0]        lt_pc;
		logic                    present;
		logic                    sel_any;
		logic signed [VAL_W-1:0] sel_value;
	} grp_sum_t;

endpackage

@@ hw/rtl/smre_cell.sv @@
// One storage cell of the sorted chain: value, valid bit, compare flags, shift.
module smre_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smre_pkg::cell_ctl_t                  ctl,
	input  logic signed [smre_pkg::VAL_W-1:0]    left_value,
	input  logic                                 left_valid,
	input  logic                                 left_le,
	input  logic signed [smre_pkg::VAL_W-1:0]    right_value,
	input  logic                                 right_valid,
	output logic signed [smre_pkg::VAL_W-1:0]    value,
	output logic                                 valid,
	output logic                                 lt,
	output logic                                 le
);

	logic signed [smre_pkg::VAL_W-1:0] value_q;
	logic                              valid_q;
	logic                              lt_s1;
	logic                              le_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_s1   <= 1'b0;
			le_s1   <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				lt_s1 <= valid_q && (value_q < ctl.value);
				le_s1 <= valid_q && (value_q <= ctl.value);
			end
			if (ctl.ins_en && !le_s1) begin
				valid_q <= left_le ? 1'b1 : left_valid;
			end else if (ctl.del_en && !lt_s1) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_en && !le_s1) begin
			value_q <= left_le ? ctl.value : left_value;
		end else if (ctl.del_en && !lt_s1) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign valid = valid_q;
	assign lt    = lt_s1;
	assign le    = le_s1;

endmodule

@@ hw/rtl/smre_group.sv @@
// Registered summary of one group of cells: thermometer count, presence, selected value.
module smre_group (
	input  logic                                                      clk,
	input  logic                                                      en,
	input  logic [smre_pkg::GROUP_SIZE-1:0]                           lt,
	input  logic [smre_pkg::GROUP_SIZE-1:0]                           le,
	input  logic [smre_pkg::GROUP_SIZE-1:0]                           sel,
	input  logic [smre_pkg::GROUP_SIZE-1:0][smre_pkg::VAL_W-1:0]      vals,
	output smre_pkg::grp_sum_t                                        sum
);

	smre_pkg::grp_sum_t sum_d;
	smre_pkg::grp_sum_t sum_s2;

	always_comb begin
		sum_d.lt_full   = &lt;
		sum_d.present   = |(le & ~lt);
		sum_d.sel_any   = |sel;
		sum_d.lt_pc     = '0;
		sum_d.sel_value = '0;
		for (int i = 0; i < smre_pkg::GROUP_SIZE; i++) begin
			sum_d.lt_pc     = sum_d.lt_pc + smre_pkg::GPC_W'(lt[i]);
			sum_d.sel_value = sum_d.sel_value | (sel[i] ? vals[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
		end
	end

	assign sum = sum_s2;

endmodule

@@ hw/rtl/sorted_multiset_rank_engine.sv @@
// Top level: ordered multiset held in a chain of cells, with group reduction and control.
//
//  channel   direction  handshake            payload
//  command   in         start / busy         cmd    (cmd_t)
//  result    out        done (1-cycle strobe) result (result_t)
//
// A transaction passes through these steps from acceptance to done: compare in every cell,
// registered group summaries, final combine with the cell shift, result register.
// busy stays high after acceptance until the result is registered; a new command is taken in the
// cycle done is shown, so the engine never works on two commands at once.
// Reset clears all valid bits and the element count; no clearing pass.
// Results cannot be stalled; done is high for exactly one cycle per command.
module sorted_multiset_rank_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  smre_pkg::cmd_t      cmd,
	output logic                done,
	output smre_pkg::result_t   result
);

	localparam int N  = smre_pkg::CAPACITY;
	localparam int GS = smre_pkg::GROUP_SIZE;
	localparam int NG = smre_pkg::NUM_GROUPS;

	smre_pkg::state_e  state_q, state_d;
	smre_pkg::cmd_t    cmd_q;
	smre_pkg::result_t result_q, result_d;
	logic              done_q;
	logic [smre_pkg::CNT_W-1:0] count_q;

	smre_pkg::cell_ctl_t ctl;
	logic [N-1:0][smre_pkg::VAL_W-1:0] cell_value;
	logic [N-1:0] cell_valid, cell_lt, cell_le, cell_sel;
	smre_pkg::grp_sum_t grp_sum [NG];

	logic [8:0] kidx;
	logic       full;
	logic       accept;
	logic       red_en;
	logic       fin;

	logic [smre_pkg::NGC_W-1:0] nfull;
	logic [smre_pkg::GPC_W-1:0] partial;
	logic [smre_pkg::CNT_W-1:0] lt_count;
	logic                       present;
	logic                       sel_any;
	logic signed [smre_pkg::VAL_W-1:0] sel_value;
	logic                       k_ok;
	logic [smre_pkg::CNT_W-1:0] count_d;

	assign accept = start && !busy;
	assign busy   = (state_q != smre_pkg::S_IDLE);
	assign full   = (count_q == smre_pkg::CNT_W'(N));
	assign kidx   = cmd_q.rank_index - 9'd1;
	assign red_en = (state_q == smre_pkg::S_RED);
	assign fin    = (state_q == smre_pkg::S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smre_pkg::S_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (fin) begin
			result_q <= result_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smre_pkg::S_IDLE: if (start) state_d = smre_pkg::S_CMP;
			smre_pkg::S_CMP:  state_d = smre_pkg::S_RED;
			smre_pkg::S_RED:  state_d = smre_pkg::S_FIN;
			smre_pkg::S_FIN:  state_d = smre_pkg::S_IDLE;
			default:          state_d = smre_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.cmp_en = (state_q == smre_pkg::S_CMP);
		ctl.ins_en = fin && (cmd_q.operation == smre_pkg::OP_INSERT) && !full;
		ctl.del_en = fin && (cmd_q.operation == smre_pkg::OP_DELETE) && present;
		ctl.value  = cmd_q.value;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [smre_pkg::VAL_W-1:0] lv, rv;
		logic lvld, lle, rvld, lt_next, le_prev;

		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
			assign lle  = 1'b1;
		end else begin : g_mid
			assign lv   = cell_value[i-1];
			assign lvld = cell_valid[i-1];
			assign lle  = cell_le[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rv      = '0;
			assign rvld    = 1'b0;
			assign lt_next = 1'b0;
		end else begin : g_inner
			assign rv      = cell_value[i+1];
			assign rvld    = cell_valid[i+1];
			assign lt_next = cell_lt[i+1];
		end
		assign le_prev = lle;

		smre_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_value  (lv),
			.left_valid  (lvld),
			.left_le     (lle),
			.right_value (rv),
			.right_valid (rvld),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.lt          (cell_lt[i]),
			.le          (cell_le[i])
		);

		always_comb begin
			case (cmd_q.operation)
				smre_pkg::OP_PRED: cell_sel[i] = cell_lt[i] && !lt_next;
				smre_pkg::OP_SUCC: cell_sel[i] = cell_valid[i] && !cell_le[i] && le_prev;
				smre_pkg::OP_KTH:  cell_sel[i] = (kidx == 9'(i));
				default:           cell_sel[i] = 1'b0;
			endcase
		end
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		smre_group u_group (
			.clk  (clk),
			.en   (red_en),
			.lt   (cell_lt[g*GS +: GS]),
			.le   (cell_le[g*GS +: GS]),
			.sel  (cell_sel[g*GS +: GS]),
			.vals (cell_value[g*GS +: GS]),
			.sum  (grp_sum[g])
		);
	end

	always_comb begin
		nfull     = '0;
		partial   = '0;
		present   = 1'b0;
		sel_any   = 1'b0;
		sel_value = '0;
		for (int g = 0; g < NG; g++) begin
			nfull     = nfull + smre_pkg::NGC_W'(grp_sum[g].lt_full);
			present   = present | grp_sum[g].present;
			sel_any   = sel_any | grp_sum[g].sel_any;
			sel_value = sel_value | grp_sum[g].sel_value;
			if (!grp_sum[g].lt_full && (g == 0 || grp_sum[(g == 0) ? 0 : g-1].lt_full)) begin
				partial = partial | grp_sum[g].lt_pc;
			end
		end
		lt_count = smre_pkg::CNT_W'({nfull, {smre_pkg::GRP_SH{1'b0}}})
			+ smre_pkg::CNT_W'(partial);
	end

	assign k_ok = (cmd_q.rank_index != 9'd0)
		&& (smre_pkg::CNT_W'(cmd_q.rank_index) <= count_q);

	always_comb begin
		count_d = count_q;
		if (ctl.ins_en) begin
			count_d = count_q + smre_pkg::CNT_W'(1);
		end else if (ctl.del_en) begin
			count_d = count_q - smre_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		result_d.answer        = '0;
		result_d.status        = smre_pkg::ST_OK;
		result_d.element_total = 9'(count_d);
		unique case (cmd_q.operation)
			smre_pkg::OP_INSERT: begin
				if (full) result_d.status = smre_pkg::ST_FULL;
			end
			smre_pkg::OP_DELETE: begin
				if (!present) result_d.status = smre_pkg::ST_NOT_FOUND;
			end
			smre_pkg::OP_RANK: begin
				result_d.answer = smre_pkg::VAL_W'(lt_count) + smre_pkg::VAL_W'(present);
			end
			smre_pkg::OP_KTH: begin
				if (k_ok) result_d.answer = sel_value;
				else      result_d.status = smre_pkg::ST_RANGE;
			end
			smre_pkg::OP_PRED: begin
				if (sel_any) begin
					result_d.answer = sel_value;
				end else begin
					result_d.answer = smre_pkg::PRED_NONE;
					result_d.status = smre_pkg::ST_NOT_FOUND;
				end
			end
			smre_pkg::OP_SUCC: begin
				if (sel_any) begin
					result_d.answer = sel_value;
				end else begin
					result_d.answer = smre_pkg::SUCC_NONE;
					result_d.status = smre_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				result_d.answer = '0;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hw/rtl/smre_checker.sv @@
// Port-level checks for the rank engine, bound to the top level.
module smre_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input smre_pkg::result_t result
);

	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result strobe missing four cycles after acceptance");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe while busy or without a preceding transaction");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.element_total <= 9'(smre_pkg::CAPACITY)))
		else $error("element total exceeds capacity");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == smre_pkg::ST_FULL)
		|-> (result.element_total == 9'(smre_pkg::CAPACITY)))
		else $error("full status with a store that is not full");

endmodule

bind sorted_multiset_rank_engine smre_checker u_smre_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ tb/sv/sorted_multiset_rank_engine_tb.sv @@
// Self-checking testbench for the sorted multiset rank engine.
`timescale 1ns / 100ps

module sorted_multiset_rank_engine_tb;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTS   = 100;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	smre_pkg::cmd_t    cmd    = '0;
	logic              busy;
	logic              done;
	smre_pkg::result_t result;

	smre_pkg::cmd_t                    cmd_queue[$];
	smre_pkg::result_t                 answers_due[$];
	logic signed [smre_pkg::VAL_W-1:0] ordered_elems[$];
	logic signed [smre_pkg::VAL_W-1:0] stim_members[$];
	int                                mismatches = 0;
	int                                n_accepted = 0;
	int                                n_checked  = 0;
	int                                quiet_cycles = 0;

	sorted_multiset_rank_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatches < MAX_PRINTS)
			$display("%0t: result %0d: %s got %0d expected %0d", $realtime, n_checked, what,
				got, want);
		mismatches++;
	endtask

	// Expected outcome of one transaction; updates the ordered contents.
	function automatic smre_pkg::result_t apply_to_multiset(smre_pkg::cmd_t c);
		smre_pkg::result_t                 r;
		logic signed [smre_pkg::VAL_W-1:0] v;
		int                                lt;
		int                                le;
		int                                k;
		r  = '0;
		v  = c.value;
		k  = c.rank_index;
		lt = 0;
		le = 0;
		foreach (ordered_elems[i]) begin
			if (ordered_elems[i] < v) lt++;
			if (ordered_elems[i] <= v) le++;
		end
		case (smre_pkg::op_e'(c.operation))
			smre_pkg::OP_INSERT: begin
				if (ordered_elems.size() >= smre_pkg::CAPACITY) r.status = smre_pkg::ST_FULL;
				else ordered_elems.insert(le, v);
			end
			smre_pkg::OP_DELETE: begin
				if (lt < ordered_elems.size() && ordered_elems[lt] == v) ordered_elems.delete(lt);
				else r.status = smre_pkg::ST_NOT_FOUND;
			end
			smre_pkg::OP_RANK: begin
				r.answer = (lt < ordered_elems.size() && ordered_elems[lt] == v) ? lt + 1 : lt;
			end
			smre_pkg::OP_KTH: begin
				if (k >= 1 && k <= ordered_elems.size()) r.answer = ordered_elems[k-1];
				else r.status = smre_pkg::ST_RANGE;
			end
			smre_pkg::OP_PRED: begin
				if (lt > 0) r.answer = ordered_elems[lt-1];
				else begin
					r.answer = smre_pkg::PRED_NONE;
					r.status = smre_pkg::ST_NOT_FOUND;
				end
			end
			smre_pkg::OP_SUCC: begin
				if (le < ordered_elems.size()) r.answer = ordered_elems[le];
				else begin
					r.answer = smre_pkg::SUCC_NONE;
					r.status = smre_pkg::ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		r.element_total = 9'(ordered_elems.size());
		return r;
	endfunction

	// Queues a command and tracks membership so deletes and k can be aimed.
	task automatic add_cmd(smre_pkg::op_e op, logic signed [smre_pkg::VAL_W-1:0] v, int k);
		smre_pkg::cmd_t c;
		int             idx;
		c.operation  = op;
		c.value      = v;
		c.rank_index = k[8:0];
		cmd_queue.push_back(c);
		idx = -1;
		if (op == smre_pkg::OP_INSERT && stim_members.size() < smre_pkg::CAPACITY)
			stim_members.push_back(v);
		if (op == smre_pkg::OP_DELETE) begin
			foreach (stim_members[i])
				if (idx < 0 && stim_members[i] == v) idx = i;
			if (idx >= 0) stim_members.delete(idx);
		end
	endtask

	function automatic logic signed [smre_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 35) return int'($urandom_range(40)) - 20;
		if (r < 55 && stim_members.size() > 0)
			return stim_members[$urandom_range(stim_members.size() - 1)];
		if (r < 65) begin
			case ($urandom_range(7))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return smre_pkg::PRED_NONE;
				3: return smre_pkg::SUCC_NONE;
				4: return -32'sd1000000001;
				5: return 32'sd1000000001;
				6: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic add_random(int ins_w, int del_w);
		int r;
		int k;
		r = $urandom_range(99);
		if ($urandom_range(99) < 60 && stim_members.size() > 0)
			k = $urandom_range(stim_members.size(), 1);
		else
			k = $urandom_range(smre_pkg::CAPACITY);
		if (r < ins_w)
			add_cmd(smre_pkg::OP_INSERT, pick_value(), k);
		else if (r < ins_w + del_w) begin
			if ($urandom_range(99) < 80 && stim_members.size() > 0)
				add_cmd(smre_pkg::OP_DELETE,
					stim_members[$urandom_range(stim_members.size() - 1)], k);
			else
				add_cmd(smre_pkg::OP_DELETE, pick_value(), k);
		end else
			add_cmd(smre_pkg::op_e'($urandom_range(smre_pkg::OP_SUCC, smre_pkg::OP_RANK)),
				pick_value(), k);
	endtask

	function automatic int idle_pct();
		if (n_accepted < 450) return 0;
		if (n_accepted < 900) return 54;
		if (n_accepted < 1350) return 0;
		return 20;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else begin
			if (start && !busy) begin
				answers_due.push_back(apply_to_multiset(cmd));
				n_accepted++;
			end
			if (!start || !busy) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct()) begin
					start <= 1'b1;
					cmd   <= cmd_queue.pop_front();
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		smre_pkg::result_t want;
		if (arst_n && done) begin
			n_checked++;
			if (answers_due.size() == 0)
				report_mismatch("result with no command pending", result.answer, 0);
			else begin
				want = answers_due.pop_front();
				if (result.answer !== want.answer)
					report_mismatch("answer", result.answer, want.answer);
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.element_total !== want.element_total)
					report_mismatch("element_total", result.element_total, want.element_total);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("** sorted_multiset_rank_engine: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		// empty store
		add_cmd(smre_pkg::OP_PRED, 32'sd0, 0);
		add_cmd(smre_pkg::OP_SUCC, 32'sd0, 0);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, 1);
		add_cmd(smre_pkg::OP_RANK, 32'sd5, 0);
		add_cmd(smre_pkg::OP_DELETE, 32'sd5, 0);
		// extremes and duplicates
		add_cmd(smre_pkg::OP_INSERT, 32'sh8000_0000, 0);
		add_cmd(smre_pkg::OP_INSERT, 32'sh7fff_ffff, 0);
		add_cmd(smre_pkg::OP_INSERT, 32'sd0, 0);
		add_cmd(smre_pkg::OP_INSERT, 32'sd0, 0);
		add_cmd(smre_pkg::OP_INSERT, smre_pkg::PRED_NONE, 0);
		add_cmd(smre_pkg::OP_RANK, 32'sd0, 0);
		add_cmd(smre_pkg::OP_RANK, 32'sd7, 0);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, 0);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, 1);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, 5);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, 6);
		add_cmd(smre_pkg::OP_KTH, 32'sd0, smre_pkg::CAPACITY);
		add_cmd(smre_pkg::OP_PRED, 32'sh8000_0000, 0);
		add_cmd(smre_pkg::OP_PRED, 32'sh7fff_ffff, 0);
		add_cmd(smre_pkg::OP_SUCC, 32'sh7fff_ffff, 0);
		add_cmd(smre_pkg::OP_SUCC, 32'sh8000_0000, 0);
		add_cmd(smre_pkg::OP_DELETE, 32'sd7, 0);
		add_cmd(smre_pkg::OP_DELETE, 32'sd0, 0);
		add_cmd(smre_pkg::OP_DELETE, 32'sh8000_0000, 0);
		// mixed traffic, fill to full and beyond, hover at full, drain, mixed again
		repeat (300) add_random(35, 25);
		while (stim_members.size() < smre_pkg::CAPACITY) add_random(70, 5);
		repeat (80) add_random(60, 10);
		while (stim_members.size() > 0) add_random(5, 70);
		repeat (600) add_random(35, 25);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || start || answers_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (answers_due.size() != 0)
			report_mismatch("results never seen", 0, answers_due.size());
		if (mismatches == 0)
			$display("** sorted_multiset_rank_engine: PASSED **");
		else
			$display("** sorted_multiset_rank_engine: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/smre_pkg.sv
hw/rtl/smre_cell.sv
hw/rtl/smre_group.sv
hw/rtl/sorted_multiset_rank_engine.sv
hw/rtl/smre_checker.sv
tb/sv/sorted_multiset_rank_engine_tb.sv
